FILE: rtl/core/cbnc_pkg.sv
// ============================================================================
// cbnc_pkg
// shared constants for the coverage bitmap novelty check
// ============================================================================
package cbnc_pkg;

    localparam int unsigned MAP_WORDS = 8192;
    localparam int unsigned POS_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned FILL_W    = $clog2(MAP_WORDS + 1);
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned BYTES     = WORD_W / 8;
    localparam int unsigned VERDICT_W = 2;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [FILL_W-1:0]    t_fill;
    typedef logic [VERDICT_W-1:0] t_verdict;

    // verdict codes
    localparam t_verdict VERDICT_NONE  = 2'd0;
    localparam t_verdict VERDICT_COUNT = 2'd1;
    localparam t_verdict VERDICT_TUPLE = 2'd2;

    localparam logic [7:0] BYTE_FRESH = 8'hff;

    // some nonzero coverage byte lands on a virgin byte that is still untouched
    function automatic logic touches_fresh_byte(t_word w, t_word v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < BYTES; k++) begin
            if ((w[8*k +: 8] != 8'd0) && (v[8*k +: 8] == BYTE_FRESH)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: rtl/core/cbnc_if.sv
// ============================================================================
// cbnc_in_if / cbnc_out_if
// valid/ready channels for coverage words in and verdicts out
// ============================================================================
interface cbnc_in_if;
    logic                valid;
    logic                ready;
    cbnc_pkg::t_word     coverage_word;
    logic                last_word;

    modport source (output valid, output coverage_word, output last_word, input ready);
    modport sink   (input valid, input coverage_word, input last_word, output ready);
endinterface

interface cbnc_out_if;
    logic                valid;
    logic                ready;
    cbnc_pkg::t_verdict  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

FILE: rtl/core/coverage_bitmap_novelty_check.sv
// ============================================================================
// coverage_bitmap_novelty_check
// checks an execution's coverage bitmap against a virgin map of unseen bits
// ============================================================================
// usage:
//   i_cov takes one 64-bit bitmap word per beat, in map order, with last_word
//   set on the final word of an execution. o_res gives one verdict beat per
//   execution: 0 nothing new, 1 only hit counts changed, 2 new tuples.
// throughput: one word per cycle unless a stall drops i_cov.ready; the virgin
//   memory is read in the cycle a word is taken and written back from the
//   memory stage; a word that hits the entry just written gets the new value
//   forwarded. The verdict register and o_res.valid load as the last word
//   leaves the memory read stage.
// reset: position, verdict and output clear at once. The virgin memory gets
//   no clearing pass; a fill count marks how far it has been written, and an
//   entry at or above it reads as all ones. Words are taken right after reset.
// stall: a verdict waits in the output register while o_res.ready is low;
//   words keep flowing until a second last word reaches the memory stage,
//   then i_cov.ready drops until the verdict is taken.
// ============================================================================
module coverage_bitmap_novelty_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cbnc_in_if.sink         i_cov,
    cbnc_out_if.source      o_res
);

    // virgin memory, one read and one write port
    cbnc_pkg::t_word mem [cbnc_pkg::MAP_WORDS];

    // issue side state
    cbnc_pkg::t_pos     r_pos, n_pos;
    cbnc_pkg::t_fill    r_fill, n_fill;

    // memory stage
    logic               r_s1_vld;
    logic               r_s1_last;
    cbnc_pkg::t_word    r_s1_word;
    cbnc_pkg::t_pos     r_s1_pos;
    logic               r_s1_fresh;     // entry never written, reads as all ones
    logic               r_s1_fwd;       // entry written on the issue edge
    cbnc_pkg::t_word    r_q;

    // last write, kept for forwarding
    cbnc_pkg::t_word    r_wr_data;

    cbnc_pkg::t_verdict r_verdict, n_verdict;
    logic               r_out_vld;
    cbnc_pkg::t_verdict r_out_verdict;

    logic               stall;
    logic               issue;
    logic               s1_adv;
    logic               wr_here;
    cbnc_pkg::t_word    virgin;
    cbnc_pkg::t_word    new_virgin;

    // only a finished verdict with nowhere to go holds the pipe
    assign stall  = r_s1_vld && r_s1_last && r_out_vld && !o_res.ready;
    assign s1_adv = r_s1_vld && !stall;
    assign issue  = i_cov.valid && !stall;
    assign i_cov.ready = !stall;

    // write of the memory stage lands on the same edge as this read
    assign wr_here = s1_adv && (r_s1_pos == r_pos);

    always_comb begin
        priority if (r_s1_fwd) begin
            virgin = r_wr_data;
        end else if (r_s1_fresh) begin
            virgin = '1;
        end else begin
            virgin = r_q;
        end
    end

    assign new_virgin = virgin & ~r_s1_word;

    always_comb begin
        n_verdict = r_verdict;
        if (((r_s1_word & virgin) != '0) && (r_verdict != cbnc_pkg::VERDICT_TUPLE)) begin
            n_verdict = cbnc_pkg::touches_fresh_byte(r_s1_word, virgin)
                      ? cbnc_pkg::VERDICT_TUPLE : cbnc_pkg::VERDICT_COUNT;
        end
    end

    // next position wraps on overrun and restarts on the last word
    always_comb begin
        n_pos  = r_pos;
        n_fill = r_fill;
        if (issue) begin
            if (i_cov.last_word || (r_pos == cbnc_pkg::t_pos'(cbnc_pkg::MAP_WORDS - 1))) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
            if (cbnc_pkg::t_fill'(r_pos) == r_fill) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // memory: read on issue, write back from the memory stage
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_q <= mem[r_pos];
        end
        if (s1_adv) begin
            mem[r_s1_pos] <= new_virgin;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_word  <= i_cov.coverage_word;
            r_s1_last  <= i_cov.last_word;
            r_s1_pos   <= r_pos;
            r_s1_fresh <= (cbnc_pkg::t_fill'(r_pos) >= r_fill);
            r_s1_fwd   <= wr_here;
        end
        if (s1_adv) begin
            r_wr_data <= new_virgin;
        end
        if (s1_adv && r_s1_last) begin
            r_out_verdict <= n_verdict;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_fill    <= '0;
            r_s1_vld  <= 1'b0;
            r_verdict <= cbnc_pkg::VERDICT_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_fill <= n_fill;
            if (!stall) begin
                r_s1_vld <= i_cov.valid;
            end
            if (s1_adv) begin
                r_verdict <= r_s1_last ? cbnc_pkg::VERDICT_NONE : n_verdict;
            end
            if (s1_adv && r_s1_last) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.verdict = r_out_verdict;

endmodule

FILE: sim/coverage_bitmap_novelty_check_tb.sv
// ============================================================================
// coverage_bitmap_novelty_check_tb
// self-checking bench: streams coverage words into the novelty check, keeps
// its own virgin map to predict each execution's verdict, and compares every
// verdict beat in order; covers directed corner cases, random executions
// under four idle/stall mixes and a long receiver hold
// ============================================================================
module coverage_bitmap_novelty_check_tb;

    // generous: well beyond what the slowest legal run needs
    localparam int unsigned CYCLE_LIMIT  = 600000;
    // verdict shows after the last word leaves the memory stage; spare cycles follow
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned RESET_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    cbnc_in_if  cov_if ();
    cbnc_out_if res_if ();

    coverage_bitmap_novelty_check u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cov   (cov_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // predictor state: unseen coverage bits, position in the map, verdict of
    // the execution in flight, and the verdicts still owed by the block
    // ------------------------------------------------------------------------
    cbnc_pkg::t_word    unseen_map [cbnc_pkg::MAP_WORDS];
    int unsigned        map_pos;
    cbnc_pkg::t_verdict exec_verdict;
    cbnc_pkg::t_verdict verdict_queue [$];
    cbnc_pkg::t_verdict expected_verdict;

    // traffic shaping, set per test
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_request;
    int unsigned hold_left;

    // bookkeeping
    int unsigned cycle_count;
    int unsigned word_count;
    int unsigned exec_count;
    int unsigned mismatch_count;
    int unsigned verdict_tally [3];

    // 10-unit clock, low then high
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run guard: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending",
                     cycle_count, verdict_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: one accepted word updates the virgin map and the verdict;
    // the word marked last closes the execution and owes one verdict
    // ------------------------------------------------------------------------
    function automatic void account_word(cbnc_pkg::t_word word, logic last);
        cbnc_pkg::t_word vw;
        logic            fresh;
        vw = unseen_map[map_pos];
        if ((word & vw) != '0) begin
            // once a new tuple is seen the byte test no longer matters
            if (exec_verdict != cbnc_pkg::VERDICT_TUPLE) begin
                fresh = 1'b0;
                for (int k = 0; k < cbnc_pkg::BYTES; k++) begin
                    if (word[8*k +: 8] != 8'h00 && vw[8*k +: 8] == cbnc_pkg::BYTE_FRESH) begin
                        fresh = 1'b1;
                    end
                end
                exec_verdict = fresh ? cbnc_pkg::VERDICT_TUPLE : cbnc_pkg::VERDICT_COUNT;
            end
            // bits seen now are no longer virgin
            unseen_map[map_pos] = vw & ~word;
        end
        // running past the map end wraps to its start
        map_pos = (map_pos == cbnc_pkg::MAP_WORDS - 1) ? 0 : map_pos + 1;
        if (last) begin
            verdict_queue.push_back(exec_verdict);
            exec_verdict = cbnc_pkg::VERDICT_NONE;
            map_pos      = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // random coverage word: mostly empty or sparse, like real bitmaps, with
    // some dense and saturated words so every bit gets both values
    // ------------------------------------------------------------------------
    function automatic cbnc_pkg::t_word draw_word();
        cbnc_pkg::t_word w;
        int unsigned     kind;
        w    = '0;
        kind = $urandom_range(99);
        if (kind < 30) begin
            w = '0;
        end else if (kind < 55) begin
            w[$urandom_range(cbnc_pkg::WORD_W - 1)] = 1'b1;
        end else if (kind < 75) begin
            w[8*$urandom_range(cbnc_pkg::BYTES - 1) +: 8] = 8'($urandom);
        end else if (kind < 90) begin
            w = {$urandom, $urandom};
        end else if (kind < 97) begin
            w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end else begin
            w = '1;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional idle cycles, then hold the beat until it is taken;
    // valid stays high into the next call so back-to-back beats never dip
    // ------------------------------------------------------------------------
    task automatic send_word(cbnc_pkg::t_word word, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            cov_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cov_if.valid         <= 1'b1;
        cov_if.coverage_word <= word;
        cov_if.last_word     <= last;
        do @(posedge i_clk); while (!(cov_if.valid && cov_if.ready));
        account_word(word, last);
        word_count++;
        if (last) begin
            exec_count++;
        end
    endtask

    // zero words that move the position without touching anything
    task automatic send_zeros(int unsigned n);
        for (int i = 0; i < n; i++) begin
            send_word('0, 1'b0);
        end
    endtask

    // sender goes quiet until every owed verdict has come back
    task automatic wait_drain();
        cov_if.valid <= 1'b0;
        while (verdict_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // checker: every verdict beat against the oldest owed verdict
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected verdict beat %0d, none pending", res_if.verdict);
                end
            end else begin
                expected_verdict = verdict_queue.pop_front();
                verdict_tally[expected_verdict]++;
                if (res_if.verdict !== expected_verdict) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("verdict mismatch: expected %0d, got %0d",
                                 expected_verdict, res_if.verdict);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // hand-picked words whose verdicts are known by inspection
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // zero word on a fresh map: nothing new
        send_word('0, 1'b1);
        // every bit of position 0 is new
        send_word('1, 1'b1);
        // same bitmap again: the virgin map remembers across executions
        send_word('1, 1'b1);
        // new tuple in byte 0 of position 1
        send_zeros(1);
        send_word(64'h0000_0000_0000_0001, 1'b1);
        // byte 0 of position 1 was hit before: only a new hit-count bit
        send_zeros(1);
        send_word(64'h0000_0000_0000_0002, 1'b1);
        // verdict tops out at position 2; later words skip the byte test
        // but still clear their virgin bits
        send_zeros(2);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'h0000_0000_0000_ff00, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        // position 3 byte 1 was cleared while the verdict sat at top
        send_zeros(3);
        send_word(64'h0000_0000_0000_ff00, 1'b1);
        // top byte of position 4 lost bit 63 already: count-only
        send_zeros(4);
        send_word(64'h4000_0000_0000_0000, 1'b1);
        // verdict from an earlier word carried to a zero last word
        send_zeros(5);
        send_word('1, 1'b0);
        send_word('0, 1'b1);
        wait_drain();
    endtask

    // random executions, mostly short, a few running up to 256 words into the map
    task automatic test_random(int unsigned n_words, int unsigned idle_pct,
                               int unsigned stall_pct);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent           = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = $urandom_range(12, 1);
            end else if (pick < 97) begin
                len = $urandom_range(48, 13);
            end else begin
                len = $urandom_range(256, 49);
            end
            for (int i = 0; i < len; i++) begin
                send_word(draw_word(), i == len - 1);
            end
            sent += len;
        end
        wait_drain();
    endtask

    // receiver holds off while the sender keeps pushing short executions,
    // so the output backs up and the input stalls
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 400;
        for (int i = 0; i < 40; i++) begin
            send_word(draw_word(), $urandom_range(2) == 0);
        end
        send_word(draw_word(), 1'b1);
        // sender pauses until every verdict is home
        wait_drain();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cov_if.valid         <= 1'b0;
        cov_if.coverage_word <= '0;
        cov_if.last_word     <= 1'b0;
        foreach (unseen_map[i]) begin
            unseen_map[i] = '1;
        end
        map_pos      = 0;
        exec_verdict = cbnc_pkg::VERDICT_NONE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(240, 0, 0);
        test_random(240, 51, 0);
        test_random(240, 0, 51);
        test_random(240, 11, 11);
        test_backpressure();

        $display("covered %0d executions, %0d words: corner cases, idle mixes, long hold",
                 exec_count, word_count);
        $display("verdicts checked: none %0d, count-only %0d, new tuple %0d; mismatches %0d",
                 verdict_tally[cbnc_pkg::VERDICT_NONE], verdict_tally[cbnc_pkg::VERDICT_COUNT],
                 verdict_tally[cbnc_pkg::VERDICT_TUPLE], mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cbnc_pkg.sv
rtl/core/cbnc_if.sv
rtl/core/coverage_bitmap_novelty_check.sv
sim/coverage_bitmap_novelty_check_tb.sv
